// ===== rtl/voxel_model_stream_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// Voxel model stream decoder assertion macros
// Shared concurrent assertion helpers for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef VOXEL_MODEL_STREAM_DECODER_DEFINES_SVH
`define VOXEL_MODEL_STREAM_DECODER_DEFINES_SVH
`ifndef ASSERT_OFF
`define VMSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define VMSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define VMSD_ASSERT(lbl, prop, msg)
`define VMSD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/vmsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Voxel model stream decoder package
// Types, codes and defaults shared by the decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none
package vmsd_pkg;

  localparam int unsigned PaletteDepthDef = 256;
  localparam int unsigned MaxDimDef       = 256;
  localparam logic [31:0] VersionWord     = 32'h0000_0101;

  typedef enum logic [3:0] {
    PH_VERSION, PH_CFMT, PH_ZAXIS, PH_COMP, PH_VIS, PH_COUNT,
    PH_NAMELEN, PH_NAME, PH_SX, PH_SY, PH_SZ, PH_PX, PH_PY, PH_PZ,
    PH_VOXEL, PH_STOP
  } phase_e;

  typedef enum logic [2:0] {
    KIND_SIZE, KIND_POS, KIND_VOXEL, KIND_DONE, KIND_ERROR
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE, ERR_VERSION, ERR_TRUNC, ERR_VIS, ERR_COMP, ERR_FULL, ERR_SIZE
  } err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    kind_e              kind;
    logic [31:0]        matrix_number;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
    logic [7:0]         material;
    logic               material_is_new;
    logic [31:0]        color_rgba;
    err_e               error_code;
    logic               last_of_run;
  } out_item_t;

  function automatic out_item_t mk_item(kind_e k, logic [31:0] mnum, logic [31:0] x,
                                        logic [31:0] y, logic [31:0] z, logic [7:0] mat,
                                        logic is_new, logic [31:0] rgba, err_e err);
    out_item_t r;
    r.kind            = k;
    r.matrix_number   = mnum;
    r.value_x         = x;
    r.value_y         = y;
    r.value_z         = z;
    r.material        = mat;
    r.material_is_new = is_new;
    r.color_rgba      = rgba;
    r.error_code      = err;
    r.last_of_run     = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/vmsd_cell.sv =====
// ----------------------------------------------------------------------------
// Palette cell
// Holds one palette color, fills when its left neighbor is filled, compares.
// ----------------------------------------------------------------------------
`default_nettype none
module vmsd_cell (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        clr_i,
  input  wire logic        app_i,
  input  wire logic        prev_valid_i,
  input  wire logic [31:0] color_i,
  output logic             valid_o,
  output logic             hit_o
);
  logic        valid_q, valid_d;
  logic [31:0] color_q;
  logic        load;

  assign load = app_i && prev_valid_i && !valid_q;

  always_comb begin
    valid_d = valid_q;
    if (clr_i) begin
      valid_d = 1'b0;
    end else if (load) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      color_q <= color_i;
    end
  end

  assign valid_o = valid_q;
  assign hit_o   = valid_q && (color_q == color_i);
endmodule
`default_nettype wire

// ===== rtl/vmsd_palette.sv =====
// ----------------------------------------------------------------------------
// Palette chain
// A row of palette cells; entry zero is never used and counts as filled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "voxel_model_stream_decoder_defines.svh"
module vmsd_palette #(
  parameter int unsigned PaletteDepth = 256
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            clr_i,
  input  wire logic                            app_i,
  input  wire logic [31:0]                     color_i,
  output logic                                 hit_o,
  output logic [$clog2(PaletteDepth)-1:0]      hit_idx_o
);
  localparam int unsigned IdxW = $clog2(PaletteDepth);

  logic [PaletteDepth-1:0] vld;
  logic [PaletteDepth-1:0] hits;

  assign vld[0]  = 1'b1;
  assign hits[0] = 1'b0;

  for (genvar i = 1; i < PaletteDepth; i++) begin : g_cell
    vmsd_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .clr_i        (clr_i),
      .app_i        (app_i),
      .prev_valid_i (vld[i-1]),
      .color_i      (color_i),
      .valid_o      (vld[i]),
      .hit_o        (hits[i])
    );
  end

  always_comb begin
    hit_idx_o = '0;
    for (int i = 1; i < PaletteDepth; i++) begin
      if (hits[i]) begin
        hit_idx_o = hit_idx_o | IdxW'(i);
      end
    end
  end

  assign hit_o = |hits;

  `VMSD_ASSERT(a_hit_unique, $onehot0(hits), "palette holds a duplicate color")
  `VMSD_ASSERT(a_fill_contiguous, app_i && !clr_i && !vld[PaletteDepth-1] |=>
    $countones(vld) == $past($countones(vld)) + 1, "palette append lost")
  `VMSD_ASSERT(a_clear, clr_i |=> $countones(vld) == 1, "palette not cleared")
endmodule
`default_nettype wire

// ===== rtl/voxel_model_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// Voxel model stream decoder
// Parses a version 1.1.0.0 voxel model byte stream into matrix and voxel
// results with a model-wide color palette.
// ----------------------------------------------------------------------------
// The input channel carries one file byte per transfer with a flag that marks
// the last byte of a stream. The output channel carries size, position,
// voxel, done and error results. A byte yields zero, one or two results,
// which are registered in a two-entry output buffer; the first shows in the
// cycle after the byte transfer. A byte that yields no result is taken every
// cycle while the buffer is empty. A byte that yields results holds off the
// next byte until the buffer has drained. The color lookup compares against
// all palette cells in the same cycle. Reset puts the parser at the version
// word with an empty palette. While the receiver stalls, the buffered result
// holds and no further byte is taken. A stream end byte returns the parser
// and palette to the reset condition.
// ----------------------------------------------------------------------------
`default_nettype none
`include "voxel_model_stream_decoder_defines.svh"
module voxel_model_stream_decoder #(
  parameter int unsigned PaletteDepth = vmsd_pkg::PaletteDepthDef,
  parameter int unsigned MaxDim       = vmsd_pkg::MaxDimDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire vmsd_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output vmsd_pkg::out_item_t      out_data_o
);
  import vmsd_pkg::*;

  localparam int unsigned FillW = $clog2(PaletteDepth + 1);
  localparam int unsigned IdxW  = $clog2(PaletteDepth);
  localparam int unsigned DimW  = $clog2(MaxDim + 1);
  localparam int unsigned CurW  = (MaxDim > 1) ? $clog2(MaxDim) : 1;

  phase_e            phase_q, phase_d, ph_w;
  logic [1:0]        byte_q, byte_d;
  logic [23:0]       shift_q, shift_d;
  logic              swap_q, swap_d, comp_q, comp_d, vis_q, vis_d;
  logic [31:0]       total_q, total_d, mcnt_q, mcnt_d, mcnt_w;
  logic [7:0]        name_q, name_d, name_dec;
  logic [DimW-1:0]   sx_q, sx_d, sy_q, sy_d, sz_q, sz_d;
  logic              sxbig_q, sxbig_d, sybig_q, sybig_d;
  logic [CurW-1:0]   cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic [31:0]       px_q, px_d, py_q, py_d;
  logic [FillW-1:0]  fill_q, fill_d;

  logic              in_acc, pop, restart;
  logic [7:0]        b;
  logic [31:0]       w, rgba, mcnt_inc;
  logic              word_hit, opaque, pal_full, app, fin_done, zero_dim, size_bad;
  logic              xw, yw, zw;
  logic              pal_hit;
  logic [IdxW-1:0]   pal_idx;
  logic [FillW-1:0]  mat_full;
  logic [FillW+7:0]  mat_ext;
  logic [7:0]        mat;

  out_item_t         r0_q, r1_q, res0, res1, wd0, wd1;
  logic [1:0]        cnt_q, cnt_d, n_res, n_wd;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (cnt_q != 2'd0);
  assign pop        = out_valid_o && !out_stall_i;
  assign b          = in_data_i.data_byte;
  assign w          = {b, shift_q};
  assign word_hit   = (byte_q == 2'd3) && (phase_q != PH_NAMELEN) &&
                      (phase_q != PH_NAME) && (phase_q != PH_STOP);
  assign opaque     = (w[31:24] != 8'd0);
  assign rgba       = swap_q ? {w[23:16], w[15:8], w[7:0], w[31:24]}
                             : {w[7:0], w[15:8], w[23:16], w[31:24]};
  assign pal_full   = !pal_hit && (fill_q >= FillW'(PaletteDepth));
  assign mat_full   = pal_hit ? FillW'(pal_idx) : fill_q;
  assign mat_ext    = {8'd0, mat_full};
  assign mat        = mat_ext[7:0];
  assign mcnt_inc   = mcnt_q + 32'd1;
  assign fin_done   = (mcnt_inc >= total_q);
  assign zero_dim   = (sx_q == '0) || (sy_q == '0) || (sz_q == '0);
  assign size_bad   = sxbig_q || sybig_q || (w > 32'(MaxDim));
  assign xw         = (DimW'(cx_q) + DimW'(1)) == sx_q;
  assign yw         = (DimW'(cy_q) + DimW'(1)) == sy_q;
  assign zw         = (DimW'(cz_q) + DimW'(1)) == sz_q;
  assign app        = in_acc && word_hit && (phase_q == PH_VOXEL) && opaque &&
                      !pal_hit && !pal_full;
  assign restart    = in_acc && in_data_i.stream_end;
  assign name_dec   = (name_q != 8'd0) ? name_q - 8'd1 : 8'd0;

  vmsd_palette #(.PaletteDepth(PaletteDepth)) u_palette (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (restart),
    .app_i     (app),
    .color_i   (rgba),
    .hit_o     (pal_hit),
    .hit_idx_o (pal_idx)
  );

  always_comb begin
    phase_d = phase_q; byte_d = byte_q; shift_d = shift_q;
    swap_d = swap_q; comp_d = comp_q; vis_d = vis_q;
    total_d = total_q; mcnt_d = mcnt_q; name_d = name_q;
    sx_d = sx_q; sy_d = sy_q; sz_d = sz_q; sxbig_d = sxbig_q; sybig_d = sybig_q;
    cx_d = cx_q; cy_d = cy_q; cz_d = cz_q; px_d = px_q; py_d = py_q;
    fill_d = fill_q;
    if (in_acc) begin
      case (phase_q)
        PH_NAMELEN: begin
          name_d  = b;
          phase_d = (b == 8'd0) ? PH_SX : PH_NAME;
          byte_d  = 2'd0;
          shift_d = '0;
        end
        PH_NAME: begin
          name_d  = name_dec;
          if (name_dec == 8'd0) begin
            phase_d = PH_SX;
          end
          byte_d  = 2'd0;
          shift_d = '0;
        end
        PH_STOP: begin
        end
        default: begin
          if (byte_q != 2'd3) begin
            byte_d = byte_q + 2'd1;
            case (byte_q)
              2'd0:    shift_d[7:0]   = b;
              2'd1:    shift_d[15:8]  = b;
              default: shift_d[23:16] = b;
            endcase
          end else begin
            byte_d  = 2'd0;
            shift_d = '0;
            case (phase_q)
              PH_VERSION: phase_d = (w == VersionWord) ? PH_CFMT : PH_STOP;
              PH_CFMT: begin
                swap_d  = (w != 32'd0);
                phase_d = PH_ZAXIS;
              end
              PH_ZAXIS: phase_d = PH_COMP;
              PH_COMP: begin
                comp_d  = (w != 32'd0);
                phase_d = PH_VIS;
              end
              PH_VIS: begin
                vis_d   = (w != 32'd0);
                phase_d = PH_COUNT;
              end
              PH_COUNT: begin
                total_d = w;
                phase_d = (vis_q || w == 32'd0) ? PH_STOP : PH_NAMELEN;
              end
              PH_SX: begin
                sx_d    = DimW'(w);
                sxbig_d = (w > 32'(MaxDim));
                phase_d = PH_SY;
              end
              PH_SY: begin
                sy_d    = DimW'(w);
                sybig_d = (w > 32'(MaxDim));
                phase_d = PH_SZ;
              end
              PH_SZ: begin
                sz_d    = DimW'(w);
                phase_d = size_bad ? PH_STOP : PH_PX;
              end
              PH_PX: begin
                px_d    = w;
                phase_d = PH_PY;
              end
              PH_PY: begin
                py_d    = w;
                phase_d = PH_PZ;
              end
              PH_PZ: begin
                if (comp_q) begin
                  phase_d = PH_STOP;
                end else begin
                  cx_d = '0; cy_d = '0; cz_d = '0;
                  if (zero_dim) begin
                    mcnt_d  = mcnt_inc;
                    phase_d = fin_done ? PH_STOP : PH_NAMELEN;
                  end else begin
                    phase_d = PH_VOXEL;
                  end
                end
              end
              PH_VOXEL: begin
                if (opaque && pal_full) begin
                  phase_d = PH_STOP;
                end else begin
                  if (app) begin
                    fill_d = fill_q + FillW'(1);
                  end
                  cx_d = xw ? '0 : cx_q + CurW'(1);
                  if (xw) begin
                    cy_d = yw ? '0 : cy_q + CurW'(1);
                    if (yw) begin
                      cz_d = zw ? '0 : cz_q + CurW'(1);
                      if (zw) begin
                        mcnt_d  = mcnt_inc;
                        phase_d = fin_done ? PH_STOP : PH_NAMELEN;
                      end
                    end
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
      endcase
    end
    ph_w   = phase_d;
    mcnt_w = mcnt_d;
    if (restart) begin
      phase_d = PH_VERSION; byte_d = 2'd0; shift_d = '0;
      swap_d = 1'b0; comp_d = 1'b0; vis_d = 1'b0;
      total_d = '0; mcnt_d = '0; name_d = '0;
      sx_d = '0; sy_d = '0; sz_d = '0; sxbig_d = 1'b0; sybig_d = 1'b0;
      cx_d = '0; cy_d = '0; cz_d = '0; px_d = '0; py_d = '0;
      fill_d = FillW'(1);
    end
  end

  always_comb begin
    wd0  = mk_item(KIND_DONE, '0, '0, '0, '0, '0, 1'b0, '0, ERR_NONE);
    wd1  = wd0;
    n_wd = 2'd0;
    if (in_acc && word_hit) begin
      case (phase_q)
        PH_VERSION: begin
          if (w != VersionWord) begin
            wd0  = mk_item(KIND_ERROR, mcnt_q, '0, '0, '0, '0, 1'b0, '0, ERR_VERSION);
            n_wd = 2'd1;
          end
        end
        PH_COUNT: begin
          if (vis_q) begin
            wd0  = mk_item(KIND_ERROR, mcnt_q, '0, '0, '0, '0, 1'b0, '0, ERR_VIS);
            n_wd = 2'd1;
          end else if (w == 32'd0) begin
            wd0  = mk_item(KIND_DONE, mcnt_q, '0, '0, '0, '0, 1'b0, '0, ERR_NONE);
            n_wd = 2'd1;
          end
        end
        PH_SZ: begin
          if (size_bad) begin
            wd0 = mk_item(KIND_ERROR, mcnt_q, '0, '0, '0, '0, 1'b0, '0, ERR_SIZE);
          end else begin
            wd0 = mk_item(KIND_SIZE, mcnt_q, 32'(sx_q), 32'(sy_q), w, '0, 1'b0, '0,
                          ERR_NONE);
          end
          n_wd = 2'd1;
        end
        PH_PZ: begin
          wd0  = mk_item(KIND_POS, mcnt_q, px_q, py_q, w, '0, 1'b0, '0, ERR_NONE);
          n_wd = 2'd1;
          if (comp_q) begin
            wd1  = mk_item(KIND_ERROR, mcnt_q, '0, '0, '0, '0, 1'b0, '0, ERR_COMP);
            n_wd = 2'd2;
          end else if (zero_dim && fin_done) begin
            wd1  = mk_item(KIND_DONE, mcnt_inc, '0, '0, '0, '0, 1'b0, '0, ERR_NONE);
            n_wd = 2'd2;
          end
        end
        PH_VOXEL: begin
          if (opaque && pal_full) begin
            wd0  = mk_item(KIND_ERROR, mcnt_q, '0, '0, '0, '0, 1'b0, '0, ERR_FULL);
            n_wd = 2'd1;
          end else begin
            if (opaque) begin
              wd0  = mk_item(KIND_VOXEL, mcnt_q, 32'(cx_q), 32'(cy_q), 32'(cz_q), mat,
                             !pal_hit, rgba, ERR_NONE);
              n_wd = 2'd1;
            end
            if (xw && yw && zw && fin_done) begin
              if (opaque) begin
                wd1  = mk_item(KIND_DONE, mcnt_inc, '0, '0, '0, '0, 1'b0, '0, ERR_NONE);
                n_wd = 2'd2;
              end else begin
                wd0  = mk_item(KIND_DONE, mcnt_inc, '0, '0, '0, '0, 1'b0, '0, ERR_NONE);
                n_wd = 2'd1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    res0  = wd0;
    res1  = wd1;
    n_res = n_wd;
    if (restart && ph_w != PH_STOP) begin
      if (n_wd == 2'd0) begin
        res0 = mk_item(KIND_ERROR, mcnt_w, '0, '0, '0, '0, 1'b0, '0, ERR_TRUNC);
      end else begin
        res1 = mk_item(KIND_ERROR, mcnt_w, '0, '0, '0, '0, 1'b0, '0, ERR_TRUNC);
      end
      n_res = n_wd + 2'd1;
    end
    if (n_res == 2'd1) begin
      res0.last_of_run = 1'b1;
    end else begin
      res1.last_of_run = 1'b1;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && n_res != 2'd0) begin
      cnt_d = n_res;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && n_res != 2'd0) begin
      r0_q <= res0;
      r1_q <= res1;
    end else if (pop) begin
      r0_q <= r1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    total_q <= total_d;
    name_q  <= name_d;
    sx_q    <= sx_d;
    sy_q    <= sy_d;
    sz_q    <= sz_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    cz_q    <= cz_d;
    px_q    <= px_d;
    py_q    <= py_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_VERSION;
      byte_q  <= 2'd0;
      swap_q  <= 1'b0;
      comp_q  <= 1'b0;
      vis_q   <= 1'b0;
      mcnt_q  <= '0;
      sxbig_q <= 1'b0;
      sybig_q <= 1'b0;
      fill_q  <= FillW'(1);
      cnt_q   <= 2'd0;
    end else begin
      phase_q <= phase_d;
      byte_q  <= byte_d;
      swap_q  <= swap_d;
      comp_q  <= comp_d;
      vis_q   <= vis_d;
      mcnt_q  <= mcnt_d;
      sxbig_q <= sxbig_d;
      sybig_q <= sybig_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = r0_q;

  `VMSD_ASSERT(a_cnt_range, cnt_q != 2'd3, "output buffer overfilled")
  `VMSD_ASSERT(a_end_restarts, restart |=> phase_q == PH_VERSION && fill_q == FillW'(1),
    "stream end did not restart the parser")
  `VMSD_ASSERT(a_fill_range, fill_q != '0 && fill_q <= FillW'(PaletteDepth),
    "palette fill count out of range")
  `VMSD_ASSERT(a_err_code, out_valid_o && out_data_o.kind == KIND_ERROR |->
    out_data_o.error_code != ERR_NONE, "error result without a code")
endmodule
`default_nettype wire
